### design/lgaa_pkg.sv
package lgaa_pkg;

    // Input item: one ray store or one zone request.
    typedef struct packed {
        logic        opcode;
        logic [9:0]  ray_index;
        logic [15:0] ray_range;
        logic        ray_finite;
        logic [2:0]  zone;
    } in_item_t;

    // Result item of an answered zone request.
    typedef struct packed {
        logic signed [15:0] aim_angle;
        logic [15:0]        object_distance;
        logic               used_default;
    } out_item_t;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [2:0] REG_FOLLOW  = 3'd0;
    localparam logic [2:0] REG_START   = 3'd1;
    localparam logic [2:0] REG_STEP    = 3'd2;
    localparam logic [2:0] REG_COUNT   = 3'd3;
    localparam logic [2:0] REG_FLOOR   = 3'd4;
    localparam logic [2:0] REG_CEIL    = 3'd5;
    localparam logic [2:0] REG_LATERAL = 3'd6;
    localparam logic [2:0] REG_DEPTH   = 3'd7;

    localparam int CORDIC_STEPS = 18;

    function automatic logic [15:0] zone_bearing(input logic [2:0] z);
        logic [15:0] r;
        begin
            unique case (z)
                3'd0: r = 16'd4369;
                3'd1: r = 16'd2185;
                3'd2: r = 16'd0;
                3'd3: r = 16'd63351;
                default: r = 16'd61167;
            endcase
            return r;
        end
    endfunction

    function automatic logic [16:0] zone_cos(input logic [2:0] z);
        logic [16:0] r;
        begin
            unique case (z)
                3'd0, 3'd4: r = 17'd59870;
                3'd1, 3'd3: r = 17'd64104;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [16:0] zone_sin(input logic [2:0] z);
        logic signed [16:0] r;
        begin
            unique case (z)
                3'd0: r = 17'sd26656;
                3'd1: r = 17'sd13626;
                3'd3: r = -17'sd13626;
                3'd4: r = -17'sd26656;
                default: r = 17'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [17:0] atan_entry(input logic [4:0] i);
        logic [17:0] r;
        begin
            unique case (i)
                5'd0: r = 18'd131072;
                5'd1: r = 18'd77376;
                5'd2: r = 18'd40884;
                5'd3: r = 18'd20753;
                5'd4: r = 18'd10417;
                5'd5: r = 18'd5213;
                5'd6: r = 18'd2607;
                5'd7: r = 18'd1304;
                5'd8: r = 18'd652;
                5'd9: r = 18'd326;
                5'd10: r = 18'd163;
                5'd11: r = 18'd81;
                5'd12: r = 18'd41;
                5'd13: r = 18'd20;
                5'd14: r = 18'd10;
                5'd15: r = 18'd5;
                5'd16: r = 18'd3;
                5'd17: r = 18'd1;
                default: r = 18'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### design/lgaa_ram.sv
module lgaa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/lidar_guided_aim_angle.sv
// Channel   Direction  Handshake         Payload
// in        input      valid / stall     lgaa_pkg::in_item_t
// out       output     valid / stall     lgaa_pkg::out_item_t
// cfg       input      valid / ready     index (3 bit), data (16 bit)
//
// A store or an ignored request does not stall the input. An answered request keeps
// the input stalled while it works: 18 index divider steps, five RAM reads and a
// drain, a setup, 19 mean divider steps (skipped on the 1000 mm fallback), the
// distance, the product and 18 CORDIC steps. The result is then held until taken
// and the input reopens the cycle after.
// Reset clears scan_present and control state; the ray RAM is not cleared.
module lidar_guided_aim_angle #(
    parameter int MAX_RAYS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lgaa_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output lgaa_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int AW = $clog2(MAX_RAYS);
    localparam int CW = $clog2(MAX_RAYS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_IDIV  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_MDIV  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_CORD  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_MEAN  = 4'd8;
    localparam logic [3:0] S_DIST  = 4'd9;

    // Configuration registers.
    logic        follow_reg;
    logic [15:0] start_reg, step_reg, floor_reg, ceil_reg;
    logic [10:0] count_reg;
    logic signed [10:0] lat_reg;
    logic [9:0]  depth_reg;
    logic        scan_present_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_reg <= 1'b0;
            start_reg  <= 16'd32768;
            step_reg   <= 16'd182;
            count_reg  <= 11'd360;
            floor_reg  <= 16'd120;
            ceil_reg   <= 16'd12000;
            lat_reg    <= 11'sd70;
            depth_reg  <= 10'd100;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lgaa_pkg::REG_FOLLOW:  follow_reg <= cfg_data[0];
                lgaa_pkg::REG_START:   start_reg  <= cfg_data;
                lgaa_pkg::REG_STEP:    step_reg   <= cfg_data;
                lgaa_pkg::REG_COUNT:   count_reg  <= cfg_data[10:0];
                lgaa_pkg::REG_FLOOR:   floor_reg  <= cfg_data;
                lgaa_pkg::REG_CEIL:    ceil_reg   <= cfg_data;
                lgaa_pkg::REG_LATERAL: lat_reg    <= cfg_data[10:0];
                default:               depth_reg  <= cfg_data[9:0];
            endcase
        end
    end

    // Effective ray count, clamped to 1..MAX_RAYS, and its last index.
    logic [CW-1:0] count_eff;
    logic [CW-1:0] last_idx;
    always_comb
    begin
        if (count_reg == 11'd0)
        begin
            count_eff = CW'(1);
        end
        else if (32'(count_reg) > MAX_RAYS)
        begin
            count_eff = CW'(MAX_RAYS);
        end
        else
        begin
            count_eff = CW'(count_reg);
        end
        last_idx = count_eff - CW'(1);
    end

    // Control state.
    logic [3:0]  state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic [2:0]  zone_reg;
    logic [16:0] rem_reg;
    logic [17:0] quo_reg;
    logic [16:0] dsr_reg;
    logic [2:0]  k_reg;
    logic [18:0] sum_reg;
    logic [2:0]  n_reg;
    logic        rd_pend_reg;
    logic [15:0] dist_reg;
    logic        dflt_reg;
    logic signed [43:0] x_reg, y_reg;
    logic signed [20:0] z_reg;
    lgaa_pkg::out_item_t out_reg;

    logic accept_in;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

    // Ray RAM: stores write, neighbor reads come from the request walk.
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [16:0]   ram_rdata;
    logic          store_hit;
    assign store_hit = accept_in && in_data.opcode == lgaa_pkg::OP_STORE
                       && 32'(in_data.ray_index) < MAX_RAYS;
    assign ram_we = store_hit;

    lgaa_ram #(.WIDTH(17), .DEPTH(MAX_RAYS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_data.ray_index)),
        .wdata ({in_data.ray_finite, in_data.ray_range}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Neighbor address, index plus k minus 2, clamped to the scan.
    logic signed [CW+1:0] nb;
    logic [CW-1:0] nb_c;
    always_comb
    begin
        nb = $signed({2'b00, quo_reg[CW-1:0]}) + $signed({{(CW-1){1'b0}}, k_reg})
             - (CW+2)'(2);
        if (nb < 0)
        begin
            nb_c = '0;
        end
        else if (nb > $signed({2'b00, last_idx}))
        begin
            nb_c = last_idx;
        end
        else
        begin
            nb_c = nb[CW-1:0];
        end
        ram_raddr = nb_c[AW-1:0];
    end

    // Restoring divider step, shared by the index and the mean.
    logic [17:0] trial;
    assign trial = {rem_reg, (state_reg == S_IDIV) ? quo_reg[17] : sum_reg[18]}
                   - {1'b0, dsr_reg};

    logic [15:0] diff;
    logic [15:0] step_eff;
    assign step_eff = (step_reg == 16'd0) ? 16'd1 : step_reg;
    assign diff = lgaa_pkg::zone_bearing(in_data.zone) - start_reg;

    logic rng_ok;
    assign rng_ok = ram_rdata[16] && ram_rdata[15:0] >= floor_reg
                    && ram_rdata[15:0] <= ceil_reg;

    // Fallback when no ray is valid or the valid rays average under 200 mm.
    logic dflt_now;
    assign dflt_now = (n_reg == 3'd0) || (sum_reg < 19'(n_reg) * 19'd200);

    logic [15:0] mean_q;
    logic [16:0] dist_w;
    logic signed [33:0] px, py;
    logic signed [43:0] xs, ys;
    logic signed [20:0] z_step;
    logic signed [20:0] z_rnd;
    always_comb
    begin
        mean_q = dflt_reg ? 16'd1000 : sum_reg[15:0];
        dist_w = {1'b0, mean_q} - {7'd0, depth_reg};
        px = $signed({1'b0, dist_reg}) * $signed({1'b0, lgaa_pkg::zone_cos(zone_reg)});
        py = $signed({1'b0, dist_reg}) * lgaa_pkg::zone_sin(zone_reg);
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        if (!y_reg[43])
        begin
            z_step = z_reg + $signed({3'b000, lgaa_pkg::atan_entry(cnt_reg)});
        end
        else
        begin
            z_step = z_reg - $signed({3'b000, lgaa_pkg::atan_entry(cnt_reg)});
        end
        z_rnd = (z_step + 21'sd8) >>> 4;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in && in_data.opcode == lgaa_pkg::OP_REQUEST
                    && follow_reg && scan_present_reg && in_data.zone <= 3'd4)
                begin
                    state_next = S_IDIV;
                end
            end
            S_IDIV:  if (cnt_reg == 5'd17) state_next = S_READ;
            S_READ:  if (k_reg == 3'd4) state_next = S_CHECK;
            S_CHECK: state_next = S_MEAN;
            S_MEAN:  state_next = dflt_now ? S_DIST : S_MDIV;
            S_MDIV:  if (cnt_reg == 5'd18) state_next = S_DIST;
            S_DIST:  state_next = S_MUL;
            S_MUL:   state_next = S_CORD;
            S_CORD:  if (cnt_reg == 5'(lgaa_pkg::CORDIC_STEPS - 1)) state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            scan_present_reg <= 1'b0;
            cnt_reg          <= '0;
            k_reg            <= '0;
            rd_pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (store_hit && CW'(in_data.ray_index) == last_idx)
            begin
                scan_present_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg     <= '0;
                    k_reg       <= '0;
                    rd_pend_reg <= 1'b0;
                end
                S_IDIV:
                begin
                    cnt_reg <= (cnt_reg == 5'd17) ? 5'd0 : cnt_reg + 5'd1;
                end
                S_READ:
                begin
                    rd_pend_reg <= 1'b1;
                    if (k_reg != 3'd4)
                    begin
                        k_reg <= k_reg + 3'd1;
                    end
                end
                S_MEAN:  cnt_reg <= '0;
                S_MDIV:  cnt_reg <= cnt_reg + 5'd1;
                S_MUL:   cnt_reg <= '0;
                S_CORD:  cnt_reg <= cnt_reg + 5'd1;
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                zone_reg <= in_data.zone;
                // Dividend 2*diff+step, divisor 2*step.
                quo_reg  <= {1'b0, diff, 1'b0} + {2'b00, step_eff};
                dsr_reg  <= {step_eff, 1'b0};
                rem_reg  <= '0;
                sum_reg  <= '0;
                n_reg    <= '0;
            end
            S_IDIV:
            begin
                if (!trial[17])
                begin
                    rem_reg <= trial[16:0];
                    quo_reg <= {quo_reg[16:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[15:0], quo_reg[17]};
                    quo_reg <= {quo_reg[16:0], 1'b0};
                end
                if (cnt_reg == 5'd17)
                begin
                    // Clamp the rounded index to the last ray.
                    if (!trial[17])
                    begin
                        if ({quo_reg[16:0], 1'b1} > 18'(last_idx))
                        begin
                            quo_reg <= 18'(last_idx);
                        end
                    end
                    else if ({quo_reg[16:0], 1'b0} > 18'(last_idx))
                    begin
                        quo_reg <= 18'(last_idx);
                    end
                end
            end
            S_READ, S_CHECK:
            begin
                if (rd_pend_reg && rng_ok)
                begin
                    sum_reg <= sum_reg + 19'(ram_rdata[15:0]);
                    n_reg   <= n_reg + 3'd1;
                end
            end
            S_MEAN:
            begin
                dflt_reg <= dflt_now;
                sum_reg  <= sum_reg + 19'(n_reg >> 1);
                dsr_reg  <= 17'(n_reg);
                rem_reg  <= '0;
            end
            S_MDIV:
            begin
                if (!trial[17])
                begin
                    rem_reg <= trial[16:0];
                    sum_reg <= {sum_reg[17:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[15:0], sum_reg[18]};
                    sum_reg <= {sum_reg[17:0], 1'b0};
                end
            end
            S_DIST:
            begin
                // Distance after the offset; 100 mm if the offset leaves zero or less.
                dist_reg <= (dist_w[16] || dist_w == 17'd0) ? 16'd100 : dist_w[15:0];
            end
            S_MUL:
            begin
                x_reg <= 44'(px);
                y_reg <= 44'(py) - 44'($signed({lat_reg, 16'd0}));
                z_reg <= '0;
            end
            S_CORD:
            begin
                z_reg <= z_step;
                if (!y_reg[43])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                end
            end
            default: ;
        endcase
        // The last CORDIC step feeds the rounded angle straight into the result.
        if (state_reg == S_CORD && cnt_reg == 5'(lgaa_pkg::CORDIC_STEPS - 1))
        begin
            out_reg.aim_angle       <= 16'(z_rnd);
            out_reg.object_distance <= dist_reg;
            out_reg.used_default    <= dflt_reg;
        end
    end

    // A result is only offered in its own state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> scan_present_reg)
        else $error("result without a scan");

endmodule
